// ===== design/assert_macros.svh =====
// Assertion macros shared by the line-of-sight unit.
// Depends on nothing; included by modules that check their own logic.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check that a property holds on every rising clock edge outside reset.
`define GLOS_ASSERT(label, clk, rst_n, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Check that an antecedent implies a consequent in the following cycle.
`define GLOS_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ===== design/glos_pkg.sv =====
// Types, constants and helpers for the grid line-of-sight unit.
// Depends on nothing; used by every module of the unit but glos_ram.
package glos_pkg;

	// Fixed grid geometry and number format
	localparam int MAX_COLS   = 64;
	localparam int MAX_ROWS   = 64;
	localparam int TILE_SIZE  = 16;
	localparam int FRAC_BITS  = 8;
	localparam int MAX_STEPS  = 256;
	localparam int COL_W      = $clog2(MAX_COLS);
	localparam int ROW_W      = $clog2(MAX_ROWS);
	localparam int ADDR_W     = COL_W + ROW_W;
	localparam int MAP_DEPTH  = MAX_COLS * MAX_ROWS;
	localparam int UNIT_SHIFT = $clog2(TILE_SIZE) + FRAC_BITS;
	localparam int UNIT       = 1 << UNIT_SHIFT;
	localparam int QUARTER    = 1 << (FRAC_BITS - 2);
	localparam int IN_W       = 20;
	localparam int CW         = 24;
	localparam int REM_W      = 16;
	localparam int PROD_W     = REM_W + CW;
	localparam int TC_W       = IN_W - UNIT_SHIFT + 2;
	localparam int STEP_W     = $clog2(MAX_STEPS);
	localparam int LIM_W      = 7;

	// Result status codes
	localparam logic [2:0] ST_WRITE   = 3'd0;
	localparam logic [2:0] ST_CLEAR   = 3'd1;
	localparam logic [2:0] ST_BLOCKED = 3'd2;
	localparam logic [2:0] ST_OUT     = 3'd3;
	localparam logic [2:0] ST_LIMIT   = 3'd4;

	// Request kinds
	localparam logic REQ_WRITE = 1'b0;
	localparam logic REQ_QUERY = 1'b1;

	// Configuration register indexes
	localparam logic CFG_COLS = 1'b0;
	localparam logic CFG_ROWS = 1'b1;

	typedef struct packed {
		logic                   req_type;
		logic [5:0]             cell_col;
		logic [5:0]             cell_row;
		logic                   cell_solid;
		logic signed [IN_W-1:0] start_x;
		logic signed [IN_W-1:0] start_y;
		logic signed [IN_W-1:0] end_x;
		logic signed [IN_W-1:0] end_y;
	} req_t;

	typedef struct packed {
		logic [2:0] status;
		logic       visible;
	} rsp_t;

	typedef enum logic [2:0] {
		S_CLEAR,
		S_IDLE,
		S_CHECK,
		S_MUL,
		S_DECIDE,
		S_DONE
	} state_t;

	// Controller to datapath commands
	typedef struct packed {
		logic clr;
		logic load;
		logic rd;
		logic mul;
		logic step;
	} cmd_t;

	// Datapath to controller status
	typedef struct packed {
		logic clr_done;
		logic out_grid;
		logic solid;
		logic at_target;
		logic last;
	} sts_t;

	// Tile index of a coordinate, truncated toward zero
	function automatic logic signed [TC_W-1:0] tile_of(input logic signed [IN_W-1:0] v);
		logic signed [IN_W:0] w;
		logic signed [IN_W:0] n;
		logic [IN_W:0]        q;
		w = (IN_W+1)'(v);
		n = -w;
		if (w < 0) begin
			q = IN_W'(0) + (n >>> UNIT_SHIFT);
			tile_of = -$signed(TC_W'(q));
		end else begin
			q = w >>> UNIT_SHIFT;
			tile_of = $signed(TC_W'(q));
		end
	endfunction

endpackage

// ===== design/glos_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
// Depends on nothing.
module glos_ram #(
	parameter int WIDTH = 1,
	parameter int DEPTH = 4096
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);
	logic [WIDTH-1:0] mem_q [DEPTH];

	// Write port
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
	end

	// Registered read port
	always_ff @(posedge clk) begin
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end
endmodule

// ===== design/glos_dp.sv =====
// Datapath of the line-of-sight unit: ray position, step math and the tile map.
// Depends on glos_pkg and glos_ram; driven by glos_ctrl commands.
module glos_dp (
	input  logic                        clk,
	input  logic                        arst_n,
	input  glos_pkg::cmd_t              cmd,
	input  glos_pkg::req_t              req,
	input  logic [glos_pkg::LIM_W-1:0] cols_lim,
	input  logic [glos_pkg::LIM_W-1:0] rows_lim,
	output glos_pkg::sts_t              sts
);
	import glos_pkg::*;

	logic [ADDR_W:0]           clr_cnt_q;
	logic signed [CW-1:0]      px_q, py_q, tx_q, ty_q;
	logic signed [TC_W-1:0]    tcx_q, tcy_q;
	logic [STEP_W-1:0]         step_q;
	logic signed [PROD_W-1:0]  prodx_q, prody_q;
	logic [CW-UNIT_SHIFT-1:0]  cx, cy;
	logic [UNIT_SHIFT-1:0]     fx, fy;
	logic signed [REM_W-1:0]   remx, remy;
	logic signed [CW-1:0]      dx, dy;
	logic signed [PROD_W-1:0]  prodx, prody;
	logic [PROD_W-1:0]         absx, absy;
	logic signed [TC_W-1:0]    cxs, cys;
	logic                      take_x;
	logic                      we;
	logic [ADDR_W-1:0]         waddr;
	logic                      wdata;
	logic [ADDR_W-1:0]         raddr;
	logic                      rdata;

	// Cell indexes and in-cell offsets of the current point
	assign cx = px_q[CW-1:UNIT_SHIFT];
	assign cy = py_q[CW-1:UNIT_SHIFT];
	assign fx = px_q[UNIT_SHIFT-1:0];
	assign fy = py_q[UNIT_SHIFT-1:0];

	// Distance to a quarter pixel past the cell boundary toward the target on each axis
	always_comb begin
		if (tx_q > px_q) begin
			remx = REM_W'(UNIT + QUARTER) - $signed({{(REM_W-UNIT_SHIFT){1'b0}}, fx});
		end else begin
			remx = -REM_W'(QUARTER) - $signed({{(REM_W-UNIT_SHIFT){1'b0}}, fx});
		end
		if (ty_q > py_q) begin
			remy = REM_W'(UNIT + QUARTER) - $signed({{(REM_W-UNIT_SHIFT){1'b0}}, fy});
		end else begin
			remy = -REM_W'(QUARTER) - $signed({{(REM_W-UNIT_SHIFT){1'b0}}, fy});
		end
	end

	assign dx    = tx_q - px_q;
	assign dy    = ty_q - py_q;
	assign prodx = PROD_W'(remx) * PROD_W'(dy);
	assign prody = PROD_W'(remy) * PROD_W'(dx);
	assign absx  = prodx_q[PROD_W-1] ? PROD_W'(-prodx_q) : PROD_W'(prodx_q);
	assign absy  = prody_q[PROD_W-1] ? PROD_W'(-prody_q) : PROD_W'(prody_q);

	assign cxs    = $signed({{(TC_W-COL_W){1'b0}}, cx[COL_W-1:0]});
	assign cys    = $signed({{(TC_W-ROW_W){1'b0}}, cy[ROW_W-1:0]});
	assign take_x = (cxs != tcx_q) && (absx < absy);

	// Status back to the controller
	assign sts.clr_done  = clr_cnt_q[ADDR_W];
	assign sts.out_grid  = px_q[CW-1] || py_q[CW-1]
		|| (cx >= (CW-UNIT_SHIFT)'(cols_lim)) || (cy >= (CW-UNIT_SHIFT)'(rows_lim));
	assign sts.solid     = rdata;
	assign sts.at_target = (cxs == tcx_q) && (cys == tcy_q);
	assign sts.last      = (step_q == STEP_W'(MAX_STEPS - 1));

	// Map write port: clearing pass or a cell write request
	always_comb begin
		we    = 1'b0;
		waddr = {req.cell_row[ROW_W-1:0], req.cell_col[COL_W-1:0]};
		wdata = req.cell_solid;
		if (cmd.clr) begin
			we    = 1'b1;
			waddr = clr_cnt_q[ADDR_W-1:0];
			wdata = 1'b0;
		end else if (cmd.load && (req.req_type == REQ_WRITE)) begin
			we = 1'b1;
		end
	end

	assign raddr = {cy[ROW_W-1:0], cx[COL_W-1:0]};

	glos_ram #(
		.WIDTH(1),
		.DEPTH(MAP_DEPTH)
	) u_map (
		.clk  (clk),
		.we   (we),
		.waddr(waddr),
		.wdata(wdata),
		.re   (cmd.rd),
		.raddr(raddr),
		.rdata(rdata)
	);

	// Advance the clearing sweep
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_cnt_q <= '0;
		end else if (cmd.clr) begin
			clr_cnt_q <= clr_cnt_q + 1'b1;
		end
	end

	// Load the ray, then advance one cell per step
	always_ff @(posedge clk) begin
		if (cmd.load) begin
			px_q   <= CW'(req.start_x);
			py_q   <= CW'(req.start_y);
			tx_q   <= CW'(req.end_x);
			ty_q   <= CW'(req.end_y);
			tcx_q  <= tile_of(req.end_x);
			tcy_q  <= tile_of(req.end_y);
			step_q <= '0;
		end else if (cmd.step) begin
			if (take_x) begin
				px_q <= px_q + CW'(remx);
			end else begin
				py_q <= py_q + CW'(remy);
			end
			step_q <= step_q + 1'b1;
		end
	end

	// Hold the cross products for the axis choice
	always_ff @(posedge clk) begin
		if (cmd.mul) begin
			prodx_q <= prodx;
			prody_q <= prody;
		end
	end

	`include "assert_macros.svh"

	`GLOS_ASSERT(a_clr_stops, clk, arst_n, !(cmd.clr && clr_cnt_q[ADDR_W]), "clear past end of map")
	`GLOS_ASSERT_NEXT(a_step_moves, clk, arst_n, cmd.step, (px_q != $past(px_q)) || (py_q != $past(py_q)), "step did not move the ray")
	`GLOS_ASSERT(a_one_cmd, clk, arst_n, $onehot0(cmd), "more than one command at once")
endmodule

// ===== design/glos_ctrl.sv =====
// Controller of the line-of-sight unit: request sequencing and result register.
// Depends on glos_pkg; commands glos_dp.
module glos_ctrl (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           req_valid,
	input  logic           req_type,
	output logic           req_stall,
	output logic           rsp_valid,
	input  logic           rsp_stall,
	output glos_pkg::rsp_t rsp,
	input  glos_pkg::sts_t sts,
	output glos_pkg::cmd_t cmd
);
	import glos_pkg::*;

	state_t     state_q, state_d;
	logic [2:0] code_q, code_d;
	logic       accept;
	logic       out_load;

	assign req_stall = (state_q != S_IDLE);
	assign accept    = req_valid && !req_stall;
	assign out_load  = (state_q == S_DONE) && (!rsp_valid || !rsp_stall);

	// State register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_CLEAR;
			code_q  <= ST_WRITE;
		end else begin
			state_q <= state_d;
			code_q  <= code_d;
		end
	end

	// Next state and commands
	always_comb begin
		state_d = state_q;
		code_d  = code_q;
		cmd     = '0;
		case (state_q)
			S_CLEAR: begin
				if (sts.clr_done) begin
					state_d = S_IDLE;
				end else begin
					cmd.clr = 1'b1;
				end
			end
			S_IDLE: begin
				if (accept) begin
					cmd.load = 1'b1;
					if (req_type == REQ_WRITE) begin
						code_d  = ST_WRITE;
						state_d = S_DONE;
					end else begin
						state_d = S_CHECK;
					end
				end
			end
			S_CHECK: begin
				if (sts.out_grid) begin
					code_d  = ST_OUT;
					state_d = S_DONE;
				end else begin
					cmd.rd  = 1'b1;
					state_d = S_MUL;
				end
			end
			S_MUL: begin
				cmd.mul = 1'b1;
				state_d = S_DECIDE;
			end
			S_DECIDE: begin
				if (sts.solid) begin
					code_d  = ST_BLOCKED;
					state_d = S_DONE;
				end else if (sts.at_target) begin
					code_d  = ST_CLEAR;
					state_d = S_DONE;
				end else if (sts.last) begin
					code_d  = ST_LIMIT;
					state_d = S_DONE;
				end else begin
					cmd.step = 1'b1;
					state_d  = S_CHECK;
				end
			end
			S_DONE: begin
				if (out_load) begin
					state_d = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	// Result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_valid <= 1'b0;
		end else if (out_load) begin
			rsp_valid <= 1'b1;
		end else if (!rsp_stall) begin
			rsp_valid <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (out_load) begin
			rsp.status  <= code_q;
			rsp.visible <= (code_q == ST_CLEAR);
		end
	end

	`include "assert_macros.svh"

	`GLOS_ASSERT_NEXT(a_accept_busy, clk, arst_n, accept, state_q == S_CHECK || state_q == S_DONE, "accepted request did not start")
	`GLOS_ASSERT(a_visible_clear, clk, arst_n, !rsp_valid || !rsp.visible || rsp.status == ST_CLEAR, "visible without clear status")
	`GLOS_ASSERT_NEXT(a_rsp_hold, clk, arst_n, rsp_valid && rsp_stall, rsp_valid && (rsp == $past(rsp)), "response changed while stalled")
endmodule

// ===== design/grid_line_of_sight_unit.sv =====
// Grid line-of-sight unit: tile map writes and ray-walk visibility queries.
// A write goes from acceptance through the done state into the result register. A
// query tests one cell at a time (check and map read, product, decide per cell) and
// ends on a solid cell, the target cell, the step limit or a cell out of grid. One request is in work at a time.
// Reset clears the map; requests stall until the clearing pass is done.
// Depends on glos_pkg, glos_ctrl and glos_dp.
module grid_line_of_sight_unit (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        req_valid,
	output logic                        req_stall,
	input  glos_pkg::req_t              req,
	output logic                        rsp_valid,
	input  logic                        rsp_stall,
	output glos_pkg::rsp_t              rsp,
	input  logic                        cfg_valid,
	output logic                        cfg_ready,
	input  logic                        cfg_index,
	input  logic [glos_pkg::LIM_W-1:0] cfg_data
);
	import glos_pkg::*;

	logic [LIM_W-1:0] cols_q, rows_q;
	logic [LIM_W-1:0] cols_lim, rows_lim;
	cmd_t             cmd;
	sts_t             sts;

	assign cfg_ready = 1'b1;

	// Configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cols_q <= LIM_W'(MAX_COLS);
			rows_q <= LIM_W'(MAX_ROWS);
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				CFG_COLS: cols_q <= cfg_data;
				CFG_ROWS: rows_q <= cfg_data;
				default:  cols_q <= cols_q;
			endcase
		end
	end

	// Clamp the grid size to the map
	assign cols_lim = (cols_q > LIM_W'(MAX_COLS)) ? LIM_W'(MAX_COLS) : cols_q;
	assign rows_lim = (rows_q > LIM_W'(MAX_ROWS)) ? LIM_W'(MAX_ROWS) : rows_q;

	glos_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.req_valid(req_valid),
		.req_type (req.req_type),
		.req_stall(req_stall),
		.rsp_valid(rsp_valid),
		.rsp_stall(rsp_stall),
		.rsp      (rsp),
		.sts      (sts),
		.cmd      (cmd)
	);

	glos_dp u_dp (
		.clk     (clk),
		.arst_n  (arst_n),
		.cmd     (cmd),
		.req     (req),
		.cols_lim(cols_lim),
		.rows_lim(rows_lim),
		.sts     (sts)
	);
endmodule
